@@ design/btmx_pkg.sv @@
`timescale 1ns / 1ps

package btmx_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;
    logic    walk;
    logic    step;
    logic    link;
    logic    build;
    logic    finish;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic empty;
    logic go;
    logic last;
    logic fits;
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/btmx_if.sv @@
`timescale 1ns / 1ps

interface btmx_item_if;
  import btmx_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

interface btmx_result_if;
  import btmx_pkg::*;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  best_xor;
  logic [VALUE_W-1:0]  running_max;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output best_xor, output running_max, output status,
                  input ready);
  modport sink (input valid, input best_xor, input running_max, input status,
                output ready);
endinterface

@@ design/btmx_ram.sv @@
`timescale 1ns / 1ps

module btmx_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/btmx_ctrl.sv @@
`timescale 1ns / 1ps

module btmx_ctrl
  import btmx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  logic     item_func,
  output logic     item_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_LINK  = 6'b000100,
    S_BUILD = 6'b001000,
    S_DONE  = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  state_t  state, state_next;
  status_t code, code_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    cmd.status = code;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load  = 1'b1;
          code_next = ST_OK;
          if (item_func == FUNC_QUERY && stat.empty) begin
            code_next  = ST_EMPTY;
            state_next = S_DONE;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.go) begin
          cmd.step = 1'b1;
          if (stat.last) begin
            state_next = S_DONE;
          end
        end else if (stat.is_query) begin
          state_next = S_DONE;
        end else if (stat.fits) begin
          state_next = S_LINK;
        end else begin
          code_next  = ST_FULL;
          state_next = S_DONE;
        end
      end
      S_LINK: begin
        cmd.link   = 1'b1;
        state_next = S_BUILD;
      end
      S_BUILD: begin
        cmd.build = 1'b1;
        if (stat.last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule

@@ design/btmx_dp.sv @@
`timescale 1ns / 1ps

module btmx_dp
  import btmx_pkg::*;
#(
  parameter int KEY_BITS   = 32,
  parameter int NODE_COUNT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               item_func,
  input  logic [VALUE_W-1:0] item_value,
  btmx_result_if.source      result
);

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int CNT_W   = $clog2(NODE_COUNT + 1);
  localparam int LVL_W   = $clog2(KEY_BITS + 1);
  localparam int ENTRY_W = 2 * NODE_W;
  localparam int SUM_W   = CNT_W + LVL_W;

  logic [KEY_BITS-1:0] key;
  logic                is_query;
  logic [KEY_BITS-1:0] pos;
  logic [LVL_W-1:0]    level;
  logic [NODE_W-1:0]   node;
  logic [KEY_BITS-1:0] acc;
  logic [ENTRY_W-1:0]  entry_q;
  logic [CNT_W-1:0]    nodes_used;
  logic [VALUE_W-1:0]  best_so_far;
  logic                set_is_empty;

  logic [KEY_BITS+VALUE_W-1:0] key_ext;
  logic [KEY_BITS+VALUE_W-1:0] acc_ext;
  logic [VALUE_W-1:0]          acc32;
  logic [VALUE_W-1:0]          max_next;
  logic [ENTRY_W-1:0]          rdata;
  logic [ENTRY_W-1:0]          entry_view;
  logic                        bit_cur;
  logic                        bit_nxt;
  logic [NODE_W-1:0]           child_same;
  logic [NODE_W-1:0]           child_other;
  logic                        same_ok;
  logic                        other_ok;
  logic [NODE_W-1:0]           next_node;
  logic [NODE_W-1:0]           fresh;
  logic [NODE_W-1:0]           fresh_inc;
  logic [SUM_W-1:0]            need_sum;
  logic                        we;
  logic [NODE_W-1:0]           waddr;
  logic [ENTRY_W-1:0]          wdata;
  logic [NODE_W-1:0]           raddr;
  logic                        re;

  assign key_ext = {{KEY_BITS{1'b0}}, item_value};
  assign acc_ext = {{VALUE_W{1'b0}}, acc};
  assign acc32   = acc_ext[VALUE_W-1:0];

  // root reads as childless until the first insert lands
  assign entry_view  = set_is_empty ? '0 : rdata;
  assign bit_cur     = |(key & pos);
  assign bit_nxt     = |(key & (pos >> 1));
  assign child_same  = bit_cur ? entry_view[ENTRY_W-1:NODE_W] : entry_view[NODE_W-1:0];
  assign child_other = bit_cur ? entry_view[NODE_W-1:0] : entry_view[ENTRY_W-1:NODE_W];
  assign same_ok     = (child_same != '0);
  assign other_ok    = (child_other != '0);
  assign next_node   = (is_query && other_ok) ? child_other : child_same;

  assign fresh     = nodes_used[NODE_W-1:0];
  assign fresh_inc = fresh + NODE_W'(1);
  assign need_sum  = SUM_W'(nodes_used) + SUM_W'(level);

  assign stat.is_query = is_query;
  assign stat.empty    = set_is_empty;
  assign stat.go       = is_query ? (other_ok || same_ok) : same_ok;
  assign stat.last     = (level == LVL_W'(1));
  assign stat.fits     = (need_sum <= SUM_W'(NODE_COUNT));
  assign stat.out_free = !result.valid || result.ready;

  assign re    = cmd.load || cmd.step;
  assign raddr = cmd.load ? '0 : next_node;
  assign we    = cmd.link || cmd.build;
  assign waddr = cmd.link ? node : fresh;

  always_comb begin
    wdata = '0;
    if (cmd.link) begin
      wdata = entry_q;
      if (bit_cur) begin
        wdata[ENTRY_W-1:NODE_W] = fresh;
      end else begin
        wdata[NODE_W-1:0] = fresh;
      end
    end else if (!stat.last) begin
      if (bit_nxt) begin
        wdata[ENTRY_W-1:NODE_W] = fresh_inc;
      end else begin
        wdata[NODE_W-1:0] = fresh_inc;
      end
    end
  end

  always_comb begin
    max_next = best_so_far;
    if (is_query && cmd.status == ST_OK && acc32 > best_so_far) begin
      max_next = acc32;
    end
  end

  btmx_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key      <= key_ext[KEY_BITS-1:0];
      is_query <= (item_func == FUNC_QUERY);
      pos      <= KEY_BITS'(1) << (KEY_BITS - 1);
      level    <= LVL_W'(KEY_BITS);
      node     <= '0;
      acc      <= '0;
    end else if (cmd.step) begin
      node  <= next_node;
      pos   <= pos >> 1;
      level <= level - LVL_W'(1);
      if (is_query && other_ok) begin
        acc <= acc | pos;
      end
    end else if (cmd.build) begin
      pos   <= pos >> 1;
      level <= level - LVL_W'(1);
    end
    if (cmd.walk) begin
      entry_q <= entry_view;
    end
    if (cmd.finish) begin
      result.best_xor    <= (is_query && cmd.status == ST_OK) ? acc32 : '0;
      result.running_max <= max_next;
      result.status      <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      nodes_used   <= CNT_W'(1);
      best_so_far  <= '0;
      set_is_empty <= 1'b1;
    end else begin
      if (cmd.finish) begin
        result.valid <= 1'b1;
        best_so_far  <= max_next;
        if (!is_query && cmd.status == ST_OK) begin
          set_is_empty <= 1'b0;
        end
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (cmd.build) begin
        nodes_used <= nodes_used + CNT_W'(1);
      end
    end
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= CNT_W'(NODE_COUNT))
    else $error("node count beyond pool");

  a_build_in_pool: assert property (@(posedge clk) disable iff (rst)
    cmd.build |-> nodes_used < CNT_W'(NODE_COUNT))
    else $error("node written outside pool");

  a_max_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> best_so_far >= $past(best_so_far))
    else $error("running maximum decreased");

  a_empty_root_only: assert property (@(posedge clk) disable iff (rst)
    set_is_empty && cmd.load |-> nodes_used == CNT_W'(1))
    else $error("nodes allocated while set empty");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == ST_EMPTY |-> result.best_xor == '0)
    else $error("empty query with nonzero answer");

endmodule

@@ design/binary_trie_max_xor.sv @@
`timescale 1ns / 1ps

// Keeps a set of unsigned KEY_BITS-wide keys in a binary trie held in a node memory of
// NODE_COUNT entries and answers maximum-XOR queries against it. Each input word is either
// an insert (func 0) or a query (func 1) and yields exactly one result word with best_xor,
// the running maximum over all queries, and a status: ok, query on an empty set, or insert
// rejected because the node pool would overflow (the trie is then left unchanged). Only the
// low KEY_BITS bits of value are used. One word is in work at a time; the node memory is
// touched once per trie level. A query walks down the trie from the root; an insert walks
// the levels that already exist and, when nodes must be added, links the first new node
// to the last existing one and then writes one new node per remaining level. A rejected
// insert and a query on an empty set add no nodes. The result sits in an output register,
// so a result waiting on the sink does not block the next input word; only the finishing
// cycle of that next word waits for the sink.
// Nodes are cleared as they are allocated, so no clearing pass runs after reset.
module binary_trie_max_xor
  import btmx_pkg::*;
#(
  parameter int KEY_BITS   = 32,
  parameter int NODE_COUNT = 4096
) (
  input logic           clk,
  input logic           rst,
  btmx_item_if.sink     item,
  btmx_result_if.source result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  btmx_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_func  (item.func),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  btmx_dp #(
    .KEY_BITS   (KEY_BITS),
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .item_func  (item.func),
    .item_value (item.value),
    .result     (result)
  );

endmodule
